/* hdl/speck_pkg.sv */
// ----------------------------------------------------------------------------
// speck_pkg
// Shared types, constants and rotate helpers for the Speck32/64 cipher unit.
// ----------------------------------------------------------------------------
package speck_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned MAX_ROUNDS = 32;
  localparam int unsigned RK_AW      = $clog2(MAX_ROUNDS);
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned ALPHA      = 7;
  localparam int unsigned BETA       = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CNT_W-1:0] RC_RESET  = CNT_W'(22);
  localparam logic [CNT_W-1:0] RC_MAX    = CNT_W'(MAX_ROUNDS);
  localparam logic [RK_AW-1:0] RK_LAST   = RK_AW'(MAX_ROUNDS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = CFG_IDX_W'(4);

  // operation select
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_PREF,
    ST_RUN
  } state_t;

  // configuration state seen by the sequencer
  typedef struct packed {
    word_t            key0;
    word_t            key1;
    word_t            key2;
    word_t            key3;
    logic [CNT_W-1:0] rounds;
    logic             sched_ready;
  } cfg_t;

  function automatic word_t rotr(input word_t x, input int unsigned s);
    return (x >> s) | (x << (WORD_W - s));
  endfunction

  function automatic word_t rotl(input word_t x, input int unsigned s);
    return (x << s) | (x >> (WORD_W - s));
  endfunction

endpackage

/* hdl/speck_ifs.sv */
// ----------------------------------------------------------------------------
// speck_ifs
// Valid/ready channel interfaces for input blocks, result blocks and config.
// ----------------------------------------------------------------------------
interface speck_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] data_left;
  logic [15:0] data_right;

  modport source (output valid, output operation, output data_left, output data_right,
                  input ready);
  modport sink (input valid, input operation, input data_left, input data_right,
                output ready);
endinterface

interface speck_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_left;
  logic [15:0] result_right;

  modport source (output valid, output result_left, output result_right, input ready);
  modport sink (input valid, input result_left, input result_right, output ready);
endinterface

interface speck_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/speck_round.sv */
// ----------------------------------------------------------------------------
// speck_round
// Shared Speck round: forward round or inverse round on one word pair.
// ----------------------------------------------------------------------------
module speck_round
  import speck_pkg::*;
(
  input  logic  op,
  input  word_t x_in,
  input  word_t y_in,
  input  word_t key,
  output word_t x_out,
  output word_t y_out
);

  word_t fwd_a;
  word_t inv_b;
  word_t inv_a;

  // forward: a = (x ror 7 + y) ^ k, y = (y rol 2) ^ a
  assign fwd_a = (rotr(x_in, ALPHA) + y_in) ^ key;

  // inverse: b = (x ^ y) ror 2, a = (x ^ k) - b
  assign inv_b = rotr(x_in ^ y_in, BETA);
  assign inv_a = (x_in ^ key) - inv_b;

  always_comb begin
    if (op == OP_DEC) begin
      x_out = rotl(inv_a, ALPHA);
      y_out = inv_b;
    end else begin
      x_out = fwd_a;
      y_out = rotl(y_in, BETA) ^ fwd_a;
    end
  end

endmodule

/* hdl/speck_cfg.sv */
// ----------------------------------------------------------------------------
// speck_cfg
// Key and round-count registers, and the schedule-valid flag.
// ----------------------------------------------------------------------------
module speck_cfg
  import speck_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  word_t                wr_data,
  input  logic                 sched_done,
  output cfg_t                 cfg
);

  word_t            key0_r, key0_nxt;
  word_t            key1_r, key1_nxt;
  word_t            key2_r, key2_nxt;
  word_t            key3_r, key3_nxt;
  logic [CNT_W-1:0] rounds_r, rounds_nxt;
  logic             sched_ready_r, sched_ready_nxt;

  // register write decode; a known register invalidates the schedule
  always_comb begin
    key0_nxt        = key0_r;
    key1_nxt        = key1_r;
    key2_nxt        = key2_r;
    key3_nxt        = key3_r;
    rounds_nxt      = rounds_r;
    sched_ready_nxt = sched_ready_r | sched_done;
    if (wr_en) begin
      unique case (wr_idx)
        REG_KEY0: begin
          key0_nxt        = wr_data;
          sched_ready_nxt = 1'b0;
        end
        REG_KEY1: begin
          key1_nxt        = wr_data;
          sched_ready_nxt = 1'b0;
        end
        REG_KEY2: begin
          key2_nxt        = wr_data;
          sched_ready_nxt = 1'b0;
        end
        REG_KEY3: begin
          key3_nxt        = wr_data;
          sched_ready_nxt = 1'b0;
        end
        REG_ROUNDS: begin
          rounds_nxt      = wr_data[CNT_W-1:0];
          sched_ready_nxt = 1'b0;
        end
        default: begin
          rounds_nxt = rounds_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r        <= '0;
      key1_r        <= '0;
      key2_r        <= '0;
      key3_r        <= '0;
      rounds_r      <= RC_RESET;
      sched_ready_r <= 1'b0;
    end else begin
      key0_r        <= key0_nxt;
      key1_r        <= key1_nxt;
      key2_r        <= key2_nxt;
      key3_r        <= key3_nxt;
      rounds_r      <= rounds_nxt;
      sched_ready_r <= sched_ready_nxt;
    end
  end

  assign cfg.key0        = key0_r;
  assign cfg.key1        = key1_r;
  assign cfg.key2        = key2_r;
  assign cfg.key3        = key3_r;
  assign cfg.rounds      = rounds_r;
  assign cfg.sched_ready = sched_ready_r;

endmodule

/* hdl/speck_ctrl.sv */
// ----------------------------------------------------------------------------
// speck_ctrl
// Sequencer, round-key store and block datapath around one shared round unit.
// ----------------------------------------------------------------------------
module speck_ctrl
  import speck_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  output logic  sched_done,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_op,
  input  word_t in_left,
  input  word_t in_right,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_left,
  output word_t out_right
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             op_r;
  word_t            dl_r, dr_r;
  word_t            sl0_r, sl1_r, sl2_r, kcur_r;
  word_t            res_l_r, res_r_r;
  word_t            rd_r;
  word_t            store [MAX_ROUNDS];

  logic             accept;
  logic             sched_last;
  logic             run_last;
  logic             finish;
  logic             no_rounds;
  logic [CNT_W-1:0] n_rounds;
  logic [CNT_W-1:0] n_last;
  logic [CNT_W-1:0] dec_idx;
  logic [RK_AW-1:0] rd_addr;
  logic             rd_op;
  logic             rnd_op;
  word_t            rnd_x, rnd_y, rnd_k;
  word_t            rnd_xo, rnd_yo;

  // effective round count, saturated to the store depth
  assign n_rounds  = (cfg.rounds > RC_MAX) ? RC_MAX : cfg.rounds;
  assign n_last    = n_rounds - CNT_W'(1);
  assign no_rounds = (n_rounds == '0);

  assign accept     = in_valid && in_ready;
  assign sched_last = (state_r == ST_SCHED) && (cnt_r[RK_AW-1:0] == RK_LAST);
  assign run_last   = no_rounds || (cnt_r == n_last);
  assign finish     = (state_r == ST_RUN) && run_last && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = cfg.sched_ready ? ST_RUN : ST_SCHED;
      end
      ST_SCHED: begin
        if (sched_last) state_nxt = ST_PREF;
      end
      ST_PREF: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    sched_done = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_SCHED: sched_done = sched_last;
      ST_PREF:  in_ready   = 1'b0;
      ST_RUN:   in_ready   = 1'b0;
      default:  in_ready   = 1'b0;
    endcase
  end

  // round / schedule index
  always_comb begin
    cnt_nxt = '0;
    case (state_r)
      ST_SCHED: cnt_nxt = sched_last ? '0 : cnt_r + CNT_W'(1);
      ST_RUN: begin
        if (!run_last)   cnt_nxt = cnt_r + CNT_W'(1);
        else if (finish) cnt_nxt = '0;
        else             cnt_nxt = cnt_r;
      end
      default: cnt_nxt = '0;
    endcase
  end

  // key read address follows the next index, so the registered key is ready once that index is current
  assign rd_op   = accept ? in_op : op_r;
  assign dec_idx = n_last - cnt_nxt;
  assign rd_addr = (rd_op == OP_DEC) ? dec_idx[RK_AW-1:0] : cnt_nxt[RK_AW-1:0];

  // shared round unit input select
  always_comb begin
    if (state_r == ST_SCHED) begin
      rnd_op = OP_ENC;
      rnd_x  = sl0_r;
      rnd_y  = kcur_r;
      rnd_k  = {{(WORD_W-RK_AW){1'b0}}, cnt_r[RK_AW-1:0]};
    end else begin
      rnd_op = op_r;
      rnd_x  = dl_r;
      rnd_y  = dr_r;
      rnd_k  = rd_r;
    end
  end

  speck_round u_round (
    .op    (rnd_op),
    .x_in  (rnd_x),
    .y_in  (rnd_y),
    .key   (rnd_k),
    .x_out (rnd_xo),
    .y_out (rnd_yo)
  );

  // round-key store
  always_ff @(posedge clk) begin
    if (state_r == ST_SCHED) store[cnt_r[RK_AW-1:0]] <= kcur_r;
    rd_r <= store[rd_addr];
  end

  // block and schedule datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      dl_r   <= in_left;
      dr_r   <= in_right;
      sl0_r  <= cfg.key2;
      sl1_r  <= cfg.key1;
      sl2_r  <= cfg.key0;
      kcur_r <= cfg.key3;
    end else if (state_r == ST_SCHED) begin
      sl0_r  <= sl1_r;
      sl1_r  <= sl2_r;
      sl2_r  <= rnd_xo;
      kcur_r <= rnd_yo;
    end else if ((state_r == ST_RUN) && !run_last) begin
      dl_r <= rnd_xo;
      dr_r <= rnd_yo;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      res_l_r <= no_rounds ? dl_r : rnd_xo;
      res_r_r <= no_rounds ? dr_r : rnd_yo;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (finish)    out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = res_l_r;
  assign out_right = res_r_r;

endmodule

/* hdl/speck32_64_block_cipher_unit.sv */
// an item with n = min(round_count, 32) rounds runs them one after another through
//   one shared round unit; with n = 0 the input words pass through unchanged
// after a key or round-count write the first item first runs the key schedule
//   through the same round unit, then its rounds
// a new item is taken only in idle, once the last one's rounds are done; a finished word
//   may wait in the output register, stalling the last round of the next item
// reset: synchronous active-low rst_n; key words clear, round_count 22, schedule invalid
// ----------------------------------------------------------------------------
// speck32_64_block_cipher_unit
// Speck32/64 encrypt/decrypt engine with on-chip key schedule.
// ----------------------------------------------------------------------------
module speck32_64_block_cipher_unit
  import speck_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  speck_in_if.sink    in_if,
  speck_out_if.source out_if,
  speck_cfg_if.sink   cfg_if
);

  cfg_t cfg;
  logic sched_done;

  // configuration port never stalls
  assign cfg_if.ready = 1'b1;

  speck_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_if.valid),
    .wr_idx     (cfg_if.index),
    .wr_data    (cfg_if.data),
    .sched_done (sched_done),
    .cfg        (cfg)
  );

  speck_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .sched_done (sched_done),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_op      (in_if.operation),
    .in_left    (in_if.data_left),
    .in_right   (in_if.data_right),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_left   (out_if.result_left),
    .out_right  (out_if.result_right)
  );

endmodule

/* hdl/speck_chk.sv */
// ----------------------------------------------------------------------------
// speck_chk
// Port-level checks for the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
module speck_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_left,
  input logic [15:0] result_right
);

  // no result word right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_left) && $stable(result_right))
    else $error("stalled result changed");

  // the engine is busy in the cycle after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result appears only as the engine goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result without return to idle");

endmodule

bind speck32_64_block_cipher_unit speck_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .result_left  (out_if.result_left),
  .result_right (out_if.result_right)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Speck32/64 cipher unit. A directed table covers
// the published test vector, zero, single and saturated round counts, spare
// register writes and all-ones keys. Random phases follow, with new keys and
// round counts between phases. Each accepted word is checked against a typed
// result or an in-bench cipher predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb
  import speck_pkg::*;
;

  localparam int TOTAL_BLOCKS = 1350;
  localparam int CALM_FROM    = 1200;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 40;
  localparam int N_DIR        = 34;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE5 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = CFG_IDX_W'(7);

  localparam logic [CFG_IDX_W-1:0] KEY_REGS [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};
  localparam logic [CFG_IDX_W-1:0] SPARE_REGS [3] = '{REG_SPARE5, REG_SPARE6, REG_SPARE7};

  typedef struct packed {
    word_t left;
    word_t right;
  } block_t;

  typedef enum bit {ROW_CFG, ROW_BLOCK} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    word_t                val;
    logic                 op;
    word_t                l;
    word_t                r;
    bit                   typed;
    block_t               want;
  } stim_row_t;

  // directed table: config rows carry idx/val, block rows carry op/l/r and
  // an optional hand-typed result
  stim_row_t dir_table [N_DIR] = '{
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'hffff, 16'hffff, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY0,   16'h1918, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY1,   16'h1110, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY2,   16'h0908, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY3,   16'h0100, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h6574, 16'h694c, 1'b1, 32'ha868_42f2},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'ha868, 16'h42f2, 1'b1, 32'h6574_694c},
    '{ROW_CFG,   REG_SPARE6, 16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h6574, 16'h694c, 1'b1, 32'ha868_42f2},
    '{ROW_CFG,   REG_ROUNDS, 16'hffc0, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h1234, 16'habcd, 1'b1, 32'h1234_abcd},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'hffff, 16'h0000, 1'b1, 32'hffff_0000},
    '{ROW_CFG,   REG_ROUNDS, 16'h0001, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'hffff, 16'hffff, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'h0000, 16'hffff, 1'b0, 32'h0},
    '{ROW_CFG,   REG_ROUNDS, 16'h0020, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h8000, 16'h0001, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'h7fff, 16'hfffe, 1'b0, 32'h0},
    '{ROW_CFG,   REG_ROUNDS, 16'h003f, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'hffff, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'h0000, 16'hffff, 1'b0, 32'h0},
    '{ROW_CFG,   REG_ROUNDS, 16'h0021, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h5555, 16'haaaa, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY0,   16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY1,   16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY2,   16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_KEY3,   16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_ROUNDS, 16'h0016, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'hffff, 16'hffff, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_DEC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_SPARE5, 16'h1234, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_CFG,   REG_SPARE7, 16'hffff, OP_ENC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0,   16'h0000, OP_ENC, 16'h0001, 16'h8000, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  speck_in_if  in_ch ();
  speck_out_if out_ch ();
  speck_cfg_if cfg_ch ();

  speck32_64_block_cipher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // cipher predictor state
  word_t            key_reg [4];
  logic [CNT_W-1:0] round_reg;
  word_t            round_keys [MAX_ROUNDS];
  bit               keys_built;

  // predicted result words, oldest first
  block_t predicted [$];
  block_t head_block;
  block_t last_block;

  int  idle_pct;
  bit  hold_out;
  int  mismatches;
  int  blocks_sent;
  int  blocks_checked;
  int  enc_sent;
  int  dec_sent;
  int  zero_round_blocks;
  int  sat_round_blocks;
  int  cfg_writes;
  int  settings_used;
  int  stall_cycles;

  always #5 clk = ~clk;

  // one forward round: left = (left ror 7 + right) ^ k, right = right rol 2 ^ left
  function automatic block_t enc_round(block_t b, word_t k);
    block_t o;
    o.left  = word_t'({b.left[6:0], b.left[15:7]} + b.right) ^ k;
    o.right = {b.right[13:0], b.right[15:14]} ^ o.left;
    return o;
  endfunction

  // exact inverse of enc_round
  function automatic block_t dec_round(block_t b, word_t k);
    block_t o;
    word_t  t;
    word_t  a;
    t       = b.right ^ b.left;
    o.right = {t[1:0], t[15:2]};
    a       = word_t'((b.left ^ k) - o.right);
    o.left  = {a[8:0], a[15:9]};
    return o;
  endfunction

  // key expansion runs the round function with the round index as key
  function automatic void expand_keys();
    word_t  lw [MAX_ROUNDS + 2];
    block_t s;
    lw[0]         = key_reg[2];
    lw[1]         = key_reg[1];
    lw[2]         = key_reg[0];
    round_keys[0] = key_reg[3];
    for (int i = 0; i < MAX_ROUNDS - 1; i++) begin
      s.left            = lw[i];
      s.right           = round_keys[i];
      s                 = enc_round(s, word_t'(i));
      lw[i + 3]         = s.left;
      round_keys[i + 1] = s.right;
    end
    keys_built = 1'b1;
  endfunction

  function automatic block_t cipher_block(logic op, word_t l, word_t r);
    block_t b;
    int     n;
    b.left  = l;
    b.right = r;
    n = (round_reg > RC_MAX) ? int'(MAX_ROUNDS) : int'(round_reg);
    if (!keys_built) expand_keys();
    if (op == OP_ENC) begin
      for (int i = 0; i < n; i++) b = enc_round(b, round_keys[i]);
    end else begin
      for (int i = n - 1; i >= 0; i--) b = dec_round(b, round_keys[i]);
    end
    return b;
  endfunction

  // register write; spare indexes leave the schedule intact
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, word_t val);
    case (idx)
      REG_KEY0:   key_reg[0] = val;
      REG_KEY1:   key_reg[1] = val;
      REG_KEY2:   key_reg[2] = val;
      REG_KEY3:   key_reg[3] = val;
      REG_ROUNDS: round_reg  = val[CNT_W-1:0];
      default:    return;
    endcase
    keys_built = 1'b0;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // drive one input word, record its prediction at acceptance
  task automatic send_block(input logic op, input word_t l, input word_t r,
                            input bit typed, input block_t want);
    block_t res;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.data_left  <= l;
    in_ch.data_right <= r;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (round_reg == '0) zero_round_blocks++;
    if (round_reg > RC_MAX) sat_round_blocks++;
    if (op == OP_ENC) enc_sent++;
    else dec_sent++;
    res = cipher_block(op, l, r);
    predicted.push_back(typed ? want : res);
    last_block = res;
    blocks_sent++;
    @(negedge clk);
  endtask

  // one register write; valid stays up for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    apply_cfg(idx, val);
    cfg_writes++;
    @(negedge clk);
  endtask

  // stop offering words until every predicted word has come back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (predicted.size() != 0);
  endtask

  // random key and round-count setting between phases
  task automatic new_settings();
    logic [CNT_W-1:0] rc;
    word_t            v;
    bit               every;
    int               pick;
    wait_results();
    every = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 4; i++) begin
      if (every || $urandom_range(0, 1) == 1) cfg_write(KEY_REGS[i], pick_word());
    end
    if (every || $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) rc = RC_RESET;
      else if (pick < 8) rc = CNT_W'($urandom_range(1, MAX_ROUNDS));
      else if (pick == 8) rc = CNT_W'($urandom_range(0, 63));
      else begin
        case ($urandom_range(0, 3))
          0:       rc = '0;
          1:       rc = CNT_W'(1);
          2:       rc = RC_MAX;
          default: rc = '1;
        endcase
      end
      // upper data bits are random and must be dropped
      v          = word_t'($urandom());
      v[CNT_W-1:0] = rc;
      cfg_write(REG_ROUNDS, v);
    end
    if ($urandom_range(0, 4) == 0) cfg_write(SPARE_REGS[$urandom_range(0, 2)], word_t'($urandom()));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // random word; a quarter decrypt the last predicted output
  task automatic random_block();
    logic  op;
    word_t l;
    word_t r;
    if ($urandom_range(0, 3) == 0) begin
      op = OP_DEC;
      l  = last_block.left;
      r  = last_block.right;
    end else begin
      op = ($urandom_range(0, 1) == 1) ? OP_DEC : OP_ENC;
      l  = pick_word();
      r  = pick_word();
    end
    send_block(op, l, r, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (predicted.size() == 0) begin
        flag_error($sformatf("unexpected word %h_%h", out_ch.result_left, out_ch.result_right));
      end else begin
        head_block = predicted.pop_front();
        if (out_ch.result_left !== head_block.left || out_ch.result_right !== head_block.right)
          flag_error($sformatf("word %0d: left exp %h got %h, right exp %h got %h",
                               blocks_checked, head_block.left, out_ch.result_left,
                               head_block.right, out_ch.result_right));
        blocks_checked++;
      end
    end
  end

  // receiver: random short stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d words outstanding",
               stall_cycles, predicted.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main stimulus
  initial begin
    int  phase;
    int  n;
    int  saved_pct;
    bit  cfg_open;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_ENC;
    in_ch.data_left  = '0;
    in_ch.data_right = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_KEY0;
    cfg_ch.data      = '0;
    hold_out         = 1'b0;
    idle_pct         = 20;
    stall_cycles     = 0;
    key_reg          = '{default: '0};
    round_reg        = RC_RESET;
    keys_built       = 1'b0;
    last_block       = '0;
    cfg_open         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        if (!cfg_open) wait_results();
        cfg_write(dir_table[i].idx, dir_table[i].val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        send_block(dir_table[i].op, dir_table[i].l, dir_table[i].r,
                   dir_table[i].typed, dir_table[i].want);
      end
    end

    // random phases, each under a fresh key / round setting
    phase = 0;
    while (blocks_sent < TOTAL_BLOCKS) begin
      new_settings();
      phase++;
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 25;
        default: idle_pct = 50;
      endcase
      if (blocks_sent >= CALM_FROM) idle_pct = 0;
      if (phase == 3) begin
        // long receiver hold-off while the sender keeps pushing
        saved_pct = idle_pct;
        idle_pct  = 0;
        hold_out  = 1'b1;
        repeat (12) random_block();
        idle_pct  = saved_pct;
      end
      n = $urandom_range(30, 90);
      for (int k = 0; k < n && blocks_sent < TOTAL_BLOCKS; k++) begin
        if (phase == 5 && k == n / 2) wait_results();
        if (blocks_sent >= CALM_FROM) idle_pct = 0;
        random_block();
      end
    end

    // drain and let any stray word show up
    wait_results();
    repeat (SETTLE) @(negedge clk);
    $display("run covered %0d words (%0d encrypt, %0d decrypt) under %0d settings, %0d reg writes",
             blocks_checked, enc_sent, dec_sent, settings_used, cfg_writes);
    $display("  %0d words with zero rounds, %0d with a saturated round count",
             zero_round_blocks, sat_round_blocks);
    if (mismatches == 0 && predicted.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
